>>> rtl/core/ltcbb_pkg.sv
package ltcbb_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [35:0] BUDGET_RESET = 36'd67108864;
    localparam logic [35:0] BYTES_MAX = 36'hF_FFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_HIT   = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_EVICT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_CHECK,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic        is_dmabuf;
        logic [63:0] device_id;
        logic [63:0] inode_id;
        logic [63:0] pixel_addr;
        logic [13:0] buf_width;
        logic [13:0] buf_height;
        logic [17:0] row_stride;
        logic [31:0] plane_offset;
        logic [31:0] format_code;
        logic [63:0] layout_modifier;
        logic [31:0] content_serial;
    } t_in_beat;

    typedef struct packed {
        t_kind       result_kind;
        logic [3:0]  entry_index;
        logic        upload_needed;
        logic [35:0] resident_total;
        logic        last_result;
    } t_out_beat;

    // request as held during its lifetime, identity already forced by kind
    typedef struct packed {
        logic        dma;
        logic [63:0] dev;
        logic [63:0] ino;
        logic [63:0] addr;
        logic [13:0] w;
        logic [13:0] h;
        logic [17:0] st;
        logic [31:0] off;
        logic [31:0] fmt;
        logic [63:0] modif;
        logic [31:0] ser;
        logic [31:0] bytes;
    } t_req;

    typedef struct packed {
        logic             touch;
        logic             set_serial;
        logic             drop;
        logic             fill;
        logic [IDX_W-1:0] idx;
        logic [63:0]      stamp;
    } t_cmd;

    typedef struct packed {
        logic             vld;
        logic             hit_found;
        logic [IDX_W-1:0] hit_idx;
        logic             hit_upl;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             old_found;
        logic [IDX_W-1:0] old_idx;
        logic [63:0]      old_stamp;
        logic [31:0]      old_bytes;
    } t_tok;

endpackage

>>> rtl/core/lru_texture_cache_byte_budget_top.sv
// channel | direction | handshake            | payload
// in      | input     | i_in_valid/o_in_stall  | i_in_data  (t_in_beat)
// out     | output    | o_out_valid/i_out_stall| o_out_data (t_out_beat)
// cfg     | input     | i_cfg_we               | i_cfg_wdata (byte budget)
// a lookup is one token walk down the row of entry cells, one cell a cycle,
// and every further eviction for the byte budget is another such walk.
// synchronous active-low reset empties every entry and sets the budget to 64 MiB.
// a stalled output beat holds the sequencer; one request is worked at a time.
module lru_texture_cache_byte_budget_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ltcbb_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ltcbb_pkg::t_out_beat o_out_data,
    input  logic                 i_cfg_we,
    input  logic [35:0]          i_cfg_wdata
);

    ltcbb_pkg::t_state r_state, n_state;
    ltcbb_pkg::t_req   r_req, n_req;
    ltcbb_pkg::t_tok   r_tok, n_tok;
    ltcbb_pkg::t_out_beat r_out, n_out;
    logic              r_out_valid;
    logic              r_phase, n_phase;
    logic              r_scan_go;
    logic [ltcbb_pkg::IDX_W-1:0] r_slot, n_slot;
    logic [63:0]       r_use_clock, n_use_clock;
    logic [35:0]       r_resident, n_resident;
    logic [35:0]       r_budget;
    ltcbb_pkg::t_cmd   cmd;
    ltcbb_pkg::t_tok   tok [ltcbb_pkg::ENTRIES+1];
    ltcbb_pkg::t_tok   tok_end;
    logic              scan_start;
    logic              out_load;
    logic              out_free;
    logic              in_acc;
    logic              over;
    logic [63:0]       clock_inc;
    logic [35:0]       res_sub;
    logic [36:0]       res_sum;
    logic [35:0]       res_add;
    logic [35:0]       bytes36;
    logic [31:0]       prod;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ltcbb_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign clock_inc = r_use_clock + 64'd1;
    assign bytes36   = {4'b0, r_req.bytes};
    assign res_sub   = (r_resident >= {4'b0, r_tok.old_bytes}) ?
                       (r_resident - {4'b0, r_tok.old_bytes}) : 36'd0;
    assign res_sum   = {1'b0, r_resident} + {1'b0, bytes36};
    assign res_add   = res_sum[36] ? ltcbb_pkg::BYTES_MAX : res_sum[35:0];
    assign over      = (r_resident != 36'd0) &&
                       ((bytes36 > r_budget) || (r_resident > r_budget - bytes36));
    assign prod      = 32'(i_in_data.row_stride) * 32'(i_in_data.buf_height);

    // row of entry cells, the scan token enters at cell 0 once the request is held
    always_comb begin
        tok[0]     = '0;
        tok[0].vld = r_scan_go;
    end

    for (genvar g = 0; g < ltcbb_pkg::ENTRIES; g++) begin : g_cell
        ltcbb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (ltcbb_pkg::IDX_W'(g)),
            .i_req   (r_req),
            .i_cmd   (cmd),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    assign tok_end = tok[ltcbb_pkg::ENTRIES];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ltcbb_pkg::ST_IDLE: begin
                if (in_acc) n_state = ltcbb_pkg::ST_SCAN;
            end
            ltcbb_pkg::ST_SCAN: begin
                if (tok_end.vld) n_state = ltcbb_pkg::ST_DECIDE;
            end
            ltcbb_pkg::ST_DECIDE: begin
                if (out_free) begin
                    if (!r_phase) begin
                        n_state = r_tok.hit_found ? ltcbb_pkg::ST_IDLE : ltcbb_pkg::ST_CHECK;
                    end else begin
                        n_state = r_tok.old_found ? ltcbb_pkg::ST_CHECK : ltcbb_pkg::ST_FILL;
                    end
                end
            end
            ltcbb_pkg::ST_CHECK: begin
                n_state = over ? ltcbb_pkg::ST_SCAN : ltcbb_pkg::ST_FILL;
            end
            ltcbb_pkg::ST_FILL: begin
                if (out_free) n_state = ltcbb_pkg::ST_IDLE;
            end
            default: n_state = ltcbb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        scan_start  = 1'b0;
        cmd         = '0;
        out_load    = 1'b0;
        n_out       = r_out;
        n_req       = r_req;
        n_tok       = r_tok;
        n_phase     = r_phase;
        n_slot      = r_slot;
        n_use_clock = r_use_clock;
        n_resident  = r_resident;
        case (r_state)
            ltcbb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_req.dma   = i_in_data.is_dmabuf;
                    n_req.dev   = i_in_data.is_dmabuf ? i_in_data.device_id : 64'd0;
                    n_req.ino   = i_in_data.is_dmabuf ? i_in_data.inode_id : 64'd0;
                    n_req.addr  = i_in_data.is_dmabuf ? 64'd0 : i_in_data.pixel_addr;
                    n_req.w     = i_in_data.buf_width;
                    n_req.h     = i_in_data.buf_height;
                    n_req.st    = i_in_data.row_stride;
                    n_req.off   = i_in_data.plane_offset;
                    n_req.fmt   = i_in_data.format_code;
                    n_req.modif = i_in_data.layout_modifier;
                    n_req.ser   = i_in_data.content_serial;
                    n_req.bytes = prod;
                    n_phase     = 1'b0;
                    scan_start  = 1'b1;
                end
            end
            ltcbb_pkg::ST_SCAN: begin
                if (tok_end.vld) n_tok = tok_end;
            end
            ltcbb_pkg::ST_DECIDE: begin
                if (out_free) begin
                    if (!r_phase && r_tok.hit_found) begin
                        n_use_clock    = clock_inc;
                        cmd.touch      = 1'b1;
                        cmd.set_serial = r_tok.hit_upl;
                        cmd.idx        = r_tok.hit_idx;
                        cmd.stamp      = clock_inc;
                        out_load       = 1'b1;
                        n_out.result_kind    = ltcbb_pkg::KIND_HIT;
                        n_out.entry_index    = 4'(r_tok.hit_idx);
                        n_out.upload_needed  = r_tok.hit_upl;
                        n_out.resident_total = r_resident;
                        n_out.last_result    = 1'b1;
                    end else if (!r_phase && r_tok.free_found) begin
                        n_slot = r_tok.free_idx;
                    end else if (r_tok.old_found) begin
                        // the oldest entry goes, its slot is taken on the first pass
                        if (!r_phase) n_slot = r_tok.old_idx;
                        cmd.drop   = 1'b1;
                        cmd.idx    = r_tok.old_idx;
                        n_resident = res_sub;
                        out_load   = 1'b1;
                        n_out.result_kind    = ltcbb_pkg::KIND_EVICT;
                        n_out.entry_index    = 4'(r_tok.old_idx);
                        n_out.upload_needed  = 1'b0;
                        n_out.resident_total = res_sub;
                        n_out.last_result    = 1'b0;
                    end
                end
            end
            ltcbb_pkg::ST_CHECK: begin
                if (over) begin
                    scan_start = 1'b1;
                    n_phase    = 1'b1;
                end
            end
            ltcbb_pkg::ST_FILL: begin
                if (out_free) begin
                    n_use_clock = clock_inc;
                    cmd.fill    = 1'b1;
                    cmd.idx     = r_slot;
                    cmd.stamp   = clock_inc;
                    n_resident  = res_add;
                    out_load    = 1'b1;
                    n_out.result_kind    = ltcbb_pkg::KIND_FILL;
                    n_out.entry_index    = 4'(r_slot);
                    n_out.upload_needed  = !r_req.dma;
                    n_out.resident_total = res_add;
                    n_out.last_result    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ltcbb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_use_clock <= '0;
            r_resident  <= '0;
            r_budget    <= ltcbb_pkg::BUDGET_RESET;
            r_phase     <= 1'b0;
            r_scan_go   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_use_clock <= n_use_clock;
            r_resident  <= n_resident;
            r_phase     <= n_phase;
            r_scan_go   <= scan_start;
            if (i_cfg_we) r_budget <= i_cfg_wdata;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_tok  <= n_tok;
        r_slot <= n_slot;
        r_out  <= n_out;
    end

    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_end.vld |-> (r_state == ltcbb_pkg::ST_SCAN))
        else $error("scan token arrived outside a scan");

    a_evict_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_result) |-> (r_state != ltcbb_pkg::ST_IDLE))
        else $error("request closed with an eviction beat last");

    a_fill_only_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fill |-> (r_state == ltcbb_pkg::ST_FILL && out_free))
        else $error("entry filled outside the fill step");

endmodule

>>> rtl/core/ltcbb_cell.sv
module ltcbb_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ltcbb_pkg::IDX_W-1:0] i_idx,
    input  ltcbb_pkg::t_req           i_req,
    input  ltcbb_pkg::t_cmd           i_cmd,
    input  ltcbb_pkg::t_tok           i_tok,
    output ltcbb_pkg::t_tok           o_tok
);

    logic            r_valid;
    ltcbb_pkg::t_req r_ent;
    logic [63:0]     r_stamp;
    ltcbb_pkg::t_tok r_tok;
    ltcbb_pkg::t_tok n_tok;
    ltcbb_pkg::t_req fill_ent;
    logic            match;
    logic            sel;

    assign sel = (i_cmd.idx == i_idx);

    assign match = r_valid && r_ent.dma == i_req.dma && r_ent.dev == i_req.dev &&
                   r_ent.ino == i_req.ino && r_ent.addr == i_req.addr &&
                   r_ent.w == i_req.w && r_ent.h == i_req.h && r_ent.st == i_req.st &&
                   r_ent.off == i_req.off && r_ent.fmt == i_req.fmt &&
                   r_ent.modif == i_req.modif;

    // fold this entry into the travelling scan token
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit_found && match) begin
            n_tok.hit_found = 1'b1;
            n_tok.hit_idx   = i_idx;
            n_tok.hit_upl   = !i_req.dma && (r_ent.ser != i_req.ser);
        end
        if (!r_valid && !i_tok.free_found) begin
            n_tok.free_found = 1'b1;
            n_tok.free_idx   = i_idx;
        end
        if (r_valid && (!i_tok.old_found || r_stamp < i_tok.old_stamp)) begin
            n_tok.old_found = 1'b1;
            n_tok.old_idx   = i_idx;
            n_tok.old_stamp = r_stamp;
            n_tok.old_bytes = r_ent.bytes;
        end
    end

    // dma buffers keep a zero serial
    always_comb begin
        fill_ent = i_req;
        if (i_req.dma) begin
            fill_ent.ser = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (sel && i_cmd.drop) begin
            r_valid <= 1'b0;
        end else if (sel && i_cmd.fill) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel && i_cmd.fill) begin
            r_ent   <= fill_ent;
            r_stamp <= i_cmd.stamp;
        end else if (sel && i_cmd.touch) begin
            r_stamp <= i_cmd.stamp;
            if (i_cmd.set_serial) begin
                r_ent.ser <= i_req.ser;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

>>> tb/sv/lru_texture_cache_byte_budget_top_tb.sv
`timescale 1ns / 1ps

module lru_texture_cache_byte_budget_top_tb;

    localparam int CYCLE_LIMIT = 1000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    ltcbb_pkg::t_in_beat  i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    ltcbb_pkg::t_out_beat o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [35:0] i_cfg_wdata = '0;

    lru_texture_cache_byte_budget_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the table
    logic        tbl_valid [ltcbb_pkg::ENTRIES];
    logic        tbl_dma [ltcbb_pkg::ENTRIES];
    logic [63:0] tbl_dev [ltcbb_pkg::ENTRIES];
    logic [63:0] tbl_ino [ltcbb_pkg::ENTRIES];
    logic [63:0] tbl_addr [ltcbb_pkg::ENTRIES];
    logic [13:0] tbl_w [ltcbb_pkg::ENTRIES];
    logic [13:0] tbl_h [ltcbb_pkg::ENTRIES];
    logic [17:0] tbl_st [ltcbb_pkg::ENTRIES];
    logic [31:0] tbl_off [ltcbb_pkg::ENTRIES];
    logic [31:0] tbl_fmt [ltcbb_pkg::ENTRIES];
    logic [63:0] tbl_mod [ltcbb_pkg::ENTRIES];
    logic [31:0] tbl_ser [ltcbb_pkg::ENTRIES];
    logic [63:0] tbl_stamp [ltcbb_pkg::ENTRIES];
    logic [31:0] tbl_bytes [ltcbb_pkg::ENTRIES];
    logic [63:0] lru_clock = '0;
    logic [35:0] resident = '0;
    logic [35:0] budget = ltcbb_pkg::BUDGET_RESET;

    ltcbb_pkg::t_in_beat  pending_reqs [$];
    ltcbb_pkg::t_out_beat expected_results [$];
    ltcbb_pkg::t_in_beat  recent_bufs [$];
    int        errors = 0;
    int        send_idle_pct = 37;
    int        recv_idle_pct = 54;
    longint    cycles = 0;

    initial begin
        for (int i = 0; i < ltcbb_pkg::ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
        end
    end

    function automatic void push_result(ltcbb_pkg::t_kind kind, int idx, logic upl,
                                        logic last);
        ltcbb_pkg::t_out_beat r;
        r.result_kind = kind;
        r.entry_index = idx[3:0];
        r.upload_needed = upl;
        r.resident_total = resident;
        r.last_result = last;
        expected_results.push_back(r);
    endfunction

    function automatic void drop_slot(int i);
        if (tbl_valid[i]) begin
            resident = (resident >= 36'(tbl_bytes[i])) ? resident - 36'(tbl_bytes[i]) : '0;
        end
        tbl_valid[i] = 1'b0;
        tbl_dma[i] = 1'b0;
        tbl_ser[i] = '0;
        tbl_stamp[i] = '0;
        tbl_bytes[i] = '0;
    endfunction

    function automatic void lookup_and_fill(ltcbb_pkg::t_in_beat b);
        logic        dma;
        logic [63:0] dev, ino, addr, need, sum;
        int          hit, free_slot, oldest, slot, victim;
        dma = b.is_dmabuf;
        dev = dma ? b.device_id : '0;
        ino = dma ? b.inode_id : '0;
        addr = dma ? '0 : b.pixel_addr;
        need = 64'(b.row_stride) * 64'(b.buf_height);
        hit = -1;
        free_slot = -1;
        oldest = -1;
        for (int i = 0; i < ltcbb_pkg::ENTRIES; i++) begin
            if (hit < 0) begin
                if (tbl_valid[i] && tbl_dma[i] == dma && tbl_dev[i] == dev && tbl_ino[i] == ino
                    && tbl_addr[i] == addr && tbl_w[i] == b.buf_width
                    && tbl_h[i] == b.buf_height && tbl_st[i] == b.row_stride
                    && tbl_off[i] == b.plane_offset && tbl_fmt[i] == b.format_code
                    && tbl_mod[i] == b.layout_modifier) begin
                    hit = i;
                end else if (!tbl_valid[i]) begin
                    if (free_slot < 0) free_slot = i;
                end else if (oldest < 0 || tbl_stamp[i] < tbl_stamp[oldest]) begin
                    oldest = i;
                end
            end
        end
        if (hit >= 0) begin
            lru_clock++;
            tbl_stamp[hit] = lru_clock;
            if (!dma && tbl_ser[hit] != b.content_serial) begin
                tbl_ser[hit] = b.content_serial;
                push_result(ltcbb_pkg::KIND_HIT, hit, 1'b1, 1'b1);
            end else begin
                push_result(ltcbb_pkg::KIND_HIT, hit, 1'b0, 1'b1);
            end
            return;
        end
        if (free_slot >= 0) begin
            slot = free_slot;
        end else begin
            slot = (oldest < 0) ? 0 : oldest;
            drop_slot(slot);
            push_result(ltcbb_pkg::KIND_EVICT, slot, 1'b0, 1'b0);
        end
        // evict oldest others while the new buffer would overrun the budget
        while (resident != 0 && (need > 64'(budget) || 64'(resident) > 64'(budget) - need)) begin
            victim = -1;
            for (int i = 0; i < ltcbb_pkg::ENTRIES; i++) begin
                if (tbl_valid[i] && i != slot
                    && (victim < 0 || tbl_stamp[i] < tbl_stamp[victim])) begin
                    victim = i;
                end
            end
            if (victim < 0) break;
            drop_slot(victim);
            push_result(ltcbb_pkg::KIND_EVICT, victim, 1'b0, 1'b0);
        end
        tbl_valid[slot] = 1'b1;
        tbl_dma[slot] = dma;
        tbl_dev[slot] = dev;
        tbl_ino[slot] = ino;
        tbl_addr[slot] = addr;
        tbl_w[slot] = b.buf_width;
        tbl_h[slot] = b.buf_height;
        tbl_st[slot] = b.row_stride;
        tbl_off[slot] = b.plane_offset;
        tbl_fmt[slot] = b.format_code;
        tbl_mod[slot] = b.layout_modifier;
        tbl_bytes[slot] = need[31:0];
        tbl_ser[slot] = dma ? '0 : b.content_serial;
        sum = 64'(resident) + need;
        resident = (sum > 64'(ltcbb_pkg::BYTES_MAX)) ? ltcbb_pkg::BYTES_MAX : sum[35:0];
        lru_clock++;
        tbl_stamp[slot] = lru_clock;
        push_result(ltcbb_pkg::KIND_FILL, slot, !dma, 1'b1);
    endfunction

    // driver
    always @(posedge i_clk) begin
        ltcbb_pkg::t_in_beat nxt;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) lookup_and_fill(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    i_in_data <= nxt;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    int beats_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        ltcbb_pkg::t_out_beat exp_beat;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                beats_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat %p", o_out_data);
                    errors++;
                end else begin
                    exp_beat = expected_results.pop_front();
                    if (o_out_data.result_kind !== exp_beat.result_kind) begin
                        $error("result_kind exp %0d got %0d", exp_beat.result_kind,
                               o_out_data.result_kind);
                        errors++;
                    end
                    if (o_out_data.entry_index !== exp_beat.entry_index) begin
                        $error("entry_index exp %0d got %0d", exp_beat.entry_index,
                               o_out_data.entry_index);
                        errors++;
                    end
                    if (o_out_data.upload_needed !== exp_beat.upload_needed) begin
                        $error("upload_needed exp %0b got %0b", exp_beat.upload_needed,
                               o_out_data.upload_needed);
                        errors++;
                    end
                    if (o_out_data.resident_total !== exp_beat.resident_total) begin
                        $error("resident_total exp %0d got %0d", exp_beat.resident_total,
                               o_out_data.resident_total);
                        errors++;
                    end
                    if (o_out_data.last_result !== exp_beat.last_result) begin
                        $error("last_result exp %0b got %0b", exp_beat.last_result,
                               o_out_data.last_result);
                        errors++;
                    end
                end
                // long hold-off so the block backs up onto its input
                if (beats_seen == 40) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic ltcbb_pkg::t_in_beat fresh_buf();
        ltcbb_pkg::t_in_beat b;
        b.is_dmabuf = 1'($urandom_range(0, 1));
        b.device_id = {$urandom, $urandom};
        b.inode_id = {$urandom, $urandom};
        b.pixel_addr = {$urandom, $urandom};
        b.plane_offset = $urandom;
        b.format_code = $urandom;
        b.layout_modifier = {$urandom, $urandom};
        b.content_serial = $urandom;
        if ($urandom_range(0, 19) == 0) begin
            b.buf_width = 14'($urandom);
            b.buf_height = 14'($urandom);
            b.row_stride = 18'($urandom);
        end else begin
            b.buf_width = 14'($urandom_range(0, 300));
            b.buf_height = 14'($urandom_range(0, 200));
            b.row_stride = 18'($urandom_range(0, 400));
        end
        return b;
    endfunction

    // about half revisits of recent buffers so hits and lru order get exercised
    task automatic queue_random(int n);
        ltcbb_pkg::t_in_beat b;
        for (int k = 0; k < n; k++) begin
            if (recent_bufs.size() > 0 && $urandom_range(0, 99) < 50) begin
                b = recent_bufs[$urandom_range(0, recent_bufs.size() - 1)];
                if ($urandom_range(0, 1)) b.content_serial = $urandom;
                if ($urandom_range(0, 9) == 0) b.format_code ^= 32'h1;
            end else begin
                b = fresh_buf();
                recent_bufs.push_back(b);
                if (recent_bufs.size() > 24) void'(recent_bufs.pop_front());
            end
            pending_reqs.push_back(b);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_budget(logic [35:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        budget = v;
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        ltcbb_pkg::t_in_beat b;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // shared memory all zero, repeat, then a changed serial
        b = '0;
        pending_reqs.push_back(b);
        pending_reqs.push_back(b);
        b.content_serial = '1;
        pending_reqs.push_back(b);
        // all-ones dma buffer is over budget and clears the rest
        b = '1;
        pending_reqs.push_back(b);
        pending_reqs.push_back(b);
        b = '1;
        b.is_dmabuf = 1'b0;
        pending_reqs.push_back(b);
        // enough distinct small buffers to force lru drops
        for (int k = 0; k < 18; k++) begin
            b = fresh_buf();
            b.buf_height = 14'(k + 1);
            b.row_stride = 18'(64);
            pending_reqs.push_back(b);
        end
        queue_random(50);
        drain();

        send_idle_pct = 54;
        recv_idle_pct = 37;
        write_budget('0);
        queue_random(45);
        drain();

        write_budget(36'd40000);
        queue_random(55);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_budget(ltcbb_pkg::BYTES_MAX);
        queue_random(55);
        drain();

        if (errors == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
